FILE: rtl/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg: shared types for the indexed list engine
// Opcodes, status codes and the command broadcast from the control logic to
// every storage cell of the list.
// ----------------------------------------------------------------------------
`default_nettype none

package ile_pkg;

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_INSERT  = 3'd1,
    OP_REMOVE  = 3'd2,
    OP_REPLACE = 3'd3,
    OP_READ    = 3'd4,
    OP_COMPARE = 3'd5,
    OP_CLEAR   = 3'd6,
    OP_NOP     = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Command seen by every cell in the same cycle.
  typedef struct packed {
    logic write;
    logic shift_up;
    logic shift_down;
  } cell_cmd_t;

  localparam int unsigned CAP_W     = 5;
  localparam int unsigned POS_W     = 5;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned CAP_RESET = 16;

endpackage

`default_nettype wire

FILE: rtl/ile_cell.sv
// ----------------------------------------------------------------------------
// ile_cell: one storage cell of the list
// Holds one entry and loads from the input value, its lower neighbor or its
// upper neighbor as the broadcast command selects. Drives its entry onto the
// read bus when its index is addressed.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_cell
  import ile_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned CNT_W      = 5,
  parameter int unsigned IDX        = 0
) (
  input  wire logic                  clk,
  input  wire cell_cmd_t             cmd,
  input  wire logic [CNT_W-1:0]      pos,
  input  wire logic [CNT_W-1:0]      count,
  input  wire logic [DATA_WIDTH-1:0] value,
  input  wire logic [DATA_WIDTH-1:0] lower_data,
  input  wire logic [DATA_WIDTH-1:0] upper_data,
  output logic      [DATA_WIDTH-1:0] data,
  output logic      [DATA_WIDTH-1:0] rd_data
);

  localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
  localparam logic [CNT_W-1:0] NEXT_C = CNT_W'(IDX + 1);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  hit;

  assign hit = (pos == IDX_C);

  always_comb begin
    data_nxt = data_r;
    if (cmd.write && hit) begin
      data_nxt = value;
    end else if (cmd.shift_up && (IDX_C > pos) && (IDX_C <= count)) begin
      data_nxt = lower_data;
    end else if (cmd.shift_down && (IDX_C >= pos) && (NEXT_C < count)) begin
      data_nxt = upper_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = hit ? data_r : '0;

endmodule

`default_nettype wire

FILE: rtl/indexed_list_engine_unit.sv
// ----------------------------------------------------------------------------
// indexed_list_engine_unit: ordered list held in a row of shifting cells
// A request's result is registered and appears in the cycle after its transfer.
// Throughput: one request per cycle while results are drained; every cell shifts in the same cycle.
// The input is taken while the result register is empty or being drained.
// Reset clears the count and the result valid flag and sets the limit to 16;
// cell contents are not reset and are only read below the count.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_engine_unit
  import ile_pkg::*;
#(
  parameter int unsigned MAX_DEPTH  = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [CAP_W-1:0]  cfg_wr_data,  // capacity_limit
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [39:0]       in_tdata,     // opcode, position, value
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // status, read_value, match, entry_count, full_flag, empty_flag
  output logic      [47:0]       out_tdata
);

  localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int unsigned CNT_W   = (DEPTH_W > POS_W) ? DEPTH_W : POS_W;
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_DEPTH);

  logic [CAP_W-1:0]  limit_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r;
  logic [47:0]       out_data_r, out_data_nxt;

  logic              accept;
  op_t               op;
  logic [CNT_W-1:0]  pos, cell_pos, lim;
  logic [VAL_W-1:0]  val;
  logic [DATA_WIDTH-1:0] val_d;
  logic              full;
  cell_cmd_t         cmd, cmd_eff;
  status_t           status;
  logic [DATA_WIDTH-1:0] rd_val;
  logic              match;
  logic              full_nxt;

  logic [DATA_WIDTH-1:0] cell_data [MAX_DEPTH];
  logic [DATA_WIDTH-1:0] cell_rd   [MAX_DEPTH];
  logic [DATA_WIDTH-1:0] rd_or;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign op    = op_t'(in_tdata[2:0]);
  assign pos   = CNT_W'(in_tdata[7:3]);
  assign val   = in_tdata[39:8];
  assign val_d = DATA_WIDTH'(val);

  always_comb begin
    lim = CNT_W'(limit_r);
    if (lim == '0) begin
      lim = CNT_W'(1);
    end else if (lim > MAX_C) begin
      lim = MAX_C;
    end
  end

  assign full = (count_r >= lim);

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  always_comb begin
    cmd       = '0;
    cell_pos  = pos;
    status    = ST_OK;
    count_nxt = count_r;
    rd_val    = '0;
    match     = 1'b0;
    case (op)
      OP_APPEND: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.write = 1'b1;
          cell_pos  = count_r;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_INSERT: begin
        if (pos > count_r) begin
          status = ST_RANGE;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          cmd.write    = 1'b1;
          cmd.shift_up = 1'b1;
          count_nxt    = count_r + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (pos >= count_r) begin
          status = ST_RANGE;
        end else begin
          cmd.shift_down = 1'b1;
          count_nxt      = count_r - CNT_W'(1);
        end
      end
      OP_REPLACE: begin
        if (pos >= count_r) begin
          status = ST_RANGE;
        end else begin
          cmd.write = 1'b1;
        end
      end
      OP_READ: begin
        if (pos >= count_r) begin
          status = ST_RANGE;
        end else begin
          rd_val = rd_or;
        end
      end
      OP_COMPARE: begin
        if (pos >= count_r) begin
          status = ST_RANGE;
        end else begin
          match = (rd_or == val_d);
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign cmd_eff  = accept ? cmd : '0;
  assign full_nxt = (count_nxt >= lim);

  assign out_data_nxt = {6'b0, (count_nxt == '0), full_nxt, count_nxt[POS_W-1:0],
                         match, VAL_W'(rd_val), status};

  for (genvar g = 0; g < MAX_DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower_d;
    logic [DATA_WIDTH-1:0] upper_d;
    if (g == 0) begin : g_first
      assign lower_d = '0;
    end else begin : g_lower
      assign lower_d = cell_data[g-1];
    end
    if (g == MAX_DEPTH - 1) begin : g_last
      assign upper_d = '0;
    end else begin : g_upper
      assign upper_d = cell_data[g+1];
    end
    ile_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd_eff),
      .pos        (cell_pos),
      .count      (count_r),
      .value      (val_d),
      .lower_data (lower_d),
      .upper_data (upper_d),
      .data       (cell_data[g]),
      .rd_data    (cell_rd[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= CAP_W'(CAP_RESET);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_C)
    else $error("list count exceeds depth");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid)
    else $error("no result after request transfer");

  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(count_r))
    else $error("count changed without a transfer");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[40] && out_tdata[41]))
    else $error("full and empty flags both set");

endmodule

`default_nettype wire

FILE: tb/indexed_list_engine_unit_test.sv
// ----------------------------------------------------------------------------
// indexed_list_engine_unit_test: self-checking bench for the indexed list engine
// A directed sequence walks every request kind and each error path. Random
// phases then run under several capacity limits, including zero and values
// above the depth, with random idling on both streams. Every result transfer
// is checked against a predicted copy of the list.
// ----------------------------------------------------------------------------
module indexed_list_engine_unit_test;
  import ile_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned PHASE_ITEMS  = 100;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] read_value;
    logic             match;
    logic [4:0]       entry_count;
    logic             full_flag;
    logic             empty_flag;
  } list_result_t;

  class list_scoreboard;
    logic [VAL_W-1:0] cells [DEPTH];
    int               count;
    logic [CAP_W-1:0] limit_reg;
    list_result_t     expected_q[$];
    int unsigned      errors;
    int unsigned      requests;
    int unsigned      results;
    int unsigned      full_seen;
    int unsigned      range_seen;
    int unsigned      match_seen;

    function new();
      count     = 0;
      limit_reg = CAP_W'(CAP_RESET);
    endfunction

    function int eff_limit();
      if (limit_reg == 0) return 1;
      if (limit_reg > DEPTH) return DEPTH;
      return limit_reg;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_request(op_t op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
      list_result_t r;
      bit           is_full;
      int           i;
      is_full = count >= eff_limit();
      r = '0;
      r.status = ST_OK;
      case (op)
        OP_APPEND: begin
          if (is_full) begin
            r.status = ST_FULL;
          end else begin
            cells[count] = val;
            count++;
          end
        end
        OP_INSERT: begin
          if (pos > count) begin
            r.status = ST_RANGE;
          end else if (is_full) begin
            r.status = ST_FULL;
          end else begin
            for (i = count; i > pos; i--) cells[i] = cells[i-1];
            cells[pos] = val;
            count++;
          end
        end
        OP_REMOVE: begin
          if (pos >= count) begin
            r.status = ST_RANGE;
          end else begin
            for (i = pos; i + 1 < count; i++) cells[i] = cells[i+1];
            count--;
          end
        end
        OP_REPLACE: begin
          if (pos >= count) r.status = ST_RANGE;
          else cells[pos] = val;
        end
        OP_READ: begin
          if (pos >= count) r.status = ST_RANGE;
          else r.read_value = cells[pos];
        end
        OP_COMPARE: begin
          if (pos >= count) r.status = ST_RANGE;
          else r.match = (cells[pos] == val);
        end
        OP_CLEAR: begin
          count = 0;
        end
        default: begin
        end
      endcase
      r.entry_count = 5'(count);
      r.full_flag   = count >= eff_limit();
      r.empty_flag  = count == 0;
      if (r.status == ST_FULL) full_seen++;
      if (r.status == ST_RANGE) range_seen++;
      if (r.match) match_seen++;
      requests++;
      expected_q.push_back(r);
    endfunction

    function void report(string field, logic [VAL_W-1:0] exp_v, logic [VAL_W-1:0] act_v);
      errors++;
      if (errors <= 10) begin
        $display("Result %0d: %s expected 0x%0h, got 0x%0h", results, field, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [47:0] bits);
      list_result_t r;
      results++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Result %0d arrived with nothing expected", results);
        return;
      end
      r = expected_q.pop_front();
      if (bits[1:0] != r.status) report("status", r.status, bits[1:0]);
      if (bits[33:2] != r.read_value) report("read_value", r.read_value, bits[33:2]);
      if (bits[34] != r.match) report("match", r.match, bits[34]);
      if (bits[39:35] != r.entry_count) report("entry_count", r.entry_count, bits[39:35]);
      if (bits[40] != r.full_flag) report("full_flag", r.full_flag, bits[40]);
      if (bits[41] != r.empty_flag) report("empty_flag", r.empty_flag, bits[41]);
    endfunction
  endclass

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             cfg_wr_en   = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data = '0;
  logic             in_tvalid   = 1'b0;
  logic             in_tready;
  logic [39:0]      in_tdata    = '0;  // opcode, position, value
  logic             out_tvalid;
  logic             out_tready  = 1'b0;
  // status, read_value, match, entry_count, full_flag, empty_flag
  logic [47:0]      out_tdata;

  list_scoreboard   sb;
  bit               tx_idle      = 1'b1;
  bit               rx_idle      = 1'b1;
  bit               hold_request = 1'b0;
  int unsigned      idle_cycles  = 0;
  int unsigned      limit_writes = 0;

  indexed_list_engine_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic send_request(op_t op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {val, pos, op};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, pos, val);
  endtask

  task automatic drain_all();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_limit(logic [CAP_W-1:0] lim);
    drain_all();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lim;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.limit_reg = lim;
    limit_writes++;
  endtask

  task automatic random_request(int unsigned grow_pct);
    op_t              op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int unsigned      pick;
    pick = $urandom_range(0, 99);
    if (pick < grow_pct) begin
      op = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 30) op = OP_REMOVE;
      else if (pick < 48) op = OP_REPLACE;
      else if (pick < 68) op = OP_READ;
      else if (pick < 94) op = OP_COMPARE;
      else if (pick < 97) op = OP_CLEAR;
      else op = OP_NOP;
    end
    if ($urandom_range(0, 9) == 0) pos = POS_W'($urandom_range(0, 31));
    else pos = POS_W'($urandom_range(0, sb.count));
    case ($urandom_range(0, 9))
      0: val = 32'h8000_0000;
      1: val = 32'h7fff_ffff;
      2: val = $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
      3, 4, 5: val = (pos < sb.count) ? sb.cells[pos] : $urandom;
      default: val = $urandom;
    endcase
    send_request(op, pos, val);
  endtask

  initial begin
    int unsigned rx_gap;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rx_gap = rx_idle ? $urandom_range(0, 19) : 0;
        if (rx_gap != 0) begin
          out_tready <= 1'b0;
          repeat (rx_gap) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_result(out_tdata);
      if ($urandom_range(0, 39) == 0) rx_idle = !rx_idle;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, sb.pending());
        $display("indexed_list_engine_unit_test: FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [CAP_W-1:0] phase_limits [9];
    int unsigned      p;
    int unsigned      n;
    sb = new();
    phase_limits = '{5'd31, 5'd0, 5'd16, 5'd5, 5'd17, 5'd1, 5'd8, 5'd2, 5'd0};
    phase_limits[8] = CAP_W'($urandom_range(0, 31));
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(OP_READ, 5'd0, 32'h1234_5678);
    send_request(OP_REMOVE, 5'd0, 32'h0);
    send_request(OP_REPLACE, 5'd0, 32'hdead_beef);
    send_request(OP_COMPARE, 5'd0, 32'h0);
    send_request(OP_INSERT, 5'd1, 32'h1);
    send_request(OP_APPEND, 5'd0, 32'h8000_0000);
    send_request(OP_APPEND, 5'd31, 32'h7fff_ffff);
    send_request(OP_INSERT, 5'd0, 32'h0);
    send_request(OP_INSERT, 5'd3, 32'hffff_ffff);
    send_request(OP_READ, 5'd3, 32'h0);
    send_request(OP_COMPARE, 5'd1, 32'h8000_0000);
    send_request(OP_COMPARE, 5'd1, 32'h0);
    send_request(OP_REPLACE, 5'd2, 32'h5555_5555);
    send_request(OP_REPLACE, 5'd4, 32'haaaa_aaaa);
    send_request(OP_READ, 5'd31, 32'h0);
    send_request(OP_REMOVE, 5'd1, 32'h0);
    send_request(OP_NOP, 5'd31, 32'hffff_ffff);
    write_limit(5'd1);
    send_request(OP_APPEND, 5'd0, 32'h1);
    send_request(OP_INSERT, 5'd0, 32'h2);
    send_request(OP_INSERT, 5'd9, 32'h3);
    send_request(OP_REMOVE, 5'd0, 32'h0);
    send_request(OP_CLEAR, 5'd16, 32'h0);
    send_request(OP_APPEND, 5'd0, 32'hcafe_f00d);
    write_limit(5'd0);
    send_request(OP_READ, 5'd0, 32'h0);
    send_request(OP_APPEND, 5'd0, 32'h4);

    for (p = 0; p < 9; p++) begin
      write_limit(phase_limits[p]);
      tx_idle = (p % 3) != 1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == 30) begin
          hold_request = 1'b1;
          tx_idle = 1'b0;
        end
        if (p == 2 && n == 60) tx_idle = 1'b1;
        if (p == 3 && n == 50) drain_all();
        random_request(((n / 25) % 2 == 0 || n >= 75) ? 65 : 20);
      end
    end

    drain_all();
    repeat (10) @(posedge clk);
    $display("Ran %0d requests and checked %0d results across %0d limit settings.",
             sb.requests, sb.results, limit_writes);
    $display("Saw %0d full rejections, %0d out-of-range requests, %0d matching compares.",
             sb.full_seen, sb.range_seen, sb.match_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("indexed_list_engine_unit_test: PASS");
    end else begin
      $display("%0d mismatches, %0d results never arrived", sb.errors, sb.pending());
      $display("indexed_list_engine_unit_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/ile_pkg.sv
rtl/ile_cell.sv
rtl/indexed_list_engine_unit.sv
tb/indexed_list_engine_unit_test.sv
